// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker (tmpu_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Consequent must hold a fixed number of cycles after the antecedent.
`define ASSERT_AFTER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("assertion failed: delayed response");

`endif

// ===== sv/tmpu_pkg.sv =====
// Package: shared types, constants and tables of the tone map pixel unit.
`timescale 1ns / 1ps
`default_nettype none

package tmpu_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int LOG_W     = 37;   // 5 integer bits, 32 fraction bits
   localparam int LOG_LAT   = 34;   // normalize (2) + 32 squarings
   localparam int EXP_STEPS = 32;
   localparam int LANE_LAT  = LOG_LAT + 2 + EXP_STEPS + 2;
   // edges from the transfer edge to the edge that takes the result
   localparam int RSP_LAT   = LANE_LAT + 2;

   typedef enum logic [1:0] {
      MODE_CLAMP    = 2'd0,
      MODE_EQUALIZE = 2'd1,
      MODE_EQ_CLAMP = 2'd2,
      MODE_GAMMA    = 2'd3
   } tm_mode_type;

   typedef enum logic [1:0] {
      CSR_MODE  = 2'd0,
      CSR_MAX   = 2'd1,
      CSR_SCALE = 2'd2,
      CSR_GAMMA = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic zero;   // input zero: result 0
      logic one;    // input at or above max, or zero exponent: result 1.0
   } gam_spec_type;

   typedef logic [31:0] exp_tab_type [EXP_STEPS];

   // 2^-(2^-i) in Q0.32 for i = 1..32, by repeated integer square roots
   function automatic exp_tab_type exp_table();
      exp_tab_type tab;
      logic [63:0] t;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bm;
      t = 64'h0000_0000_8000_0000;
      for (int i = 0; i < EXP_STEPS; i++) begin
         v   = t << 32;
         res = 64'd0;
         bm  = 64'd1 << 62;
         while (bm > v) bm = bm >> 2;
         while (bm != 64'd0) begin
            if (v >= res + bm) begin
               v   = v - (res + bm);
               res = (res >> 1) + bm;
            end else begin
               res = res >> 1;
            end
            bm = bm >> 2;
         end
         t      = res;
         tab[i] = t[31:0];
      end
      return tab;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tone_map_pixel_unit.sv =====
// Top level of the tone map pixel unit: registers, lanes and output stage.
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel HDR tone mapper. A pixel transfer happens at a rising edge with
// start high and busy low; busy is high only during reset, so one pixel may be
// taken every cycle. Each pixel gives exactly one result, shown on the rsp_
// ports for one cycle with rsp_valid high, in transfer order; its delay from the
// transfer edge is tmpu_pkg::RSP_LAT. The receiver cannot stall: results must
// be taken when shown. The latency is set by the gamma path: the input register,
// a 34-stage log2 (leading one detect, normalize, 32 squarings), two stages for
// the log difference and exponent product, a 32-stage exp2 multiplier chain, a
// rounding stage, the lane output register and the output stage; the divider and
// clamp paths are padded to match, so all modes have the same latency. Registers
// are written through csr_we/csr_index/csr_wdata; the user must write them only
// while no pixel is in flight, which the block itself does not enforce. Mode:
// 0 clamp, 1 equalize, 2 equalize and clamp, 3 equalize and gamma. A zero max
// value is stored as 1. Inputs are unsigned Q16.16, outputs Q1.16 saturated at
// 1.0 (by default).

module tone_map_pixel_unit #(
   parameter int FRAC_BITS = tmpu_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // pixel input
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_red_in,
   input  logic [31:0]        req_green_in,
   input  logic [31:0]        req_blue_in,
   // result output
   output logic               rsp_valid,
   output logic [FRAC_BITS:0] rsp_red_out,
   output logic [FRAC_BITS:0] rsp_green_out,
   output logic [FRAC_BITS:0] rsp_blue_out,
   // register writes
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import tmpu_pkg::*;

   // ---------------- registers ----------------
   tm_mode_type mode_ff;
   logic [31:0] max_value_ff;
   logic [31:0] clamp_scale_ff;
   logic [15:0] gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_CLAMP;
         max_value_ff   <= 32'd65536;
         clamp_scale_ff <= 32'd65536;
         gamma_ff       <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:  mode_ff        <= tm_mode_type'(csr_wdata[1:0]);
            // zero max is taken as the smallest nonzero value
            CSR_MAX:   max_value_ff   <= (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
            CSR_SCALE: clamp_scale_ff <= csr_wdata;
            CSR_GAMMA: gamma_ff       <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- input stage ----------------
   logic        accept;
   logic [31:0] red_ff;
   logic [31:0] green_ff;
   logic [31:0] blue_ff;
   logic        vld_ff [LANE_LAT+1];

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
      end
   end

   // transfer marker follows the pixel through the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LANE_LAT; i++) vld_ff[i] <= 1'b0;
      end else begin
         for (int i = 0; i <= LANE_LAT; i++) begin
            vld_ff[i] <= (i == 0) ? accept : vld_ff[i-1];
         end
      end
   end

   // ---------------- shared log2 of max ----------------
   // Free running; the user must keep max stable while pixels are in flight
   // (the block does not enforce it), so its output lines up with the lane logs.
   logic [LOG_W-1:0] log_max;

   tmpu_log2 u_log_max (
      .clock   (clock),
      .value   (max_value_ff),
      .log_out (log_max)
   );

   // ---------------- lanes ----------------
   logic [FRAC_BITS:0] lane_red;
   logic [FRAC_BITS:0] lane_green;
   logic [FRAC_BITS:0] lane_blue;

   tmpu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
      .clock          (clock),
      .pixel          (red_ff),
      .mode           (mode_ff),
      .max_value      (max_value_ff),
      .clamp_scale    (clamp_scale_ff),
      .gamma_exponent (gamma_ff),
      .log_max        (log_max),
      .result         (lane_red)
   );

   tmpu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
      .clock          (clock),
      .pixel          (green_ff),
      .mode           (mode_ff),
      .max_value      (max_value_ff),
      .clamp_scale    (clamp_scale_ff),
      .gamma_exponent (gamma_ff),
      .log_max        (log_max),
      .result         (lane_green)
   );

   tmpu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
      .clock          (clock),
      .pixel          (blue_ff),
      .mode           (mode_ff),
      .max_value      (max_value_ff),
      .clamp_scale    (clamp_scale_ff),
      .gamma_exponent (gamma_ff),
      .log_max        (log_max),
      .result         (lane_blue)
   );

   // ---------------- output stage ----------------
   tmpu_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock         (clock),
      .reset         (reset),
      .lane_valid    (vld_ff[LANE_LAT]),
      .lane_red      (lane_red),
      .lane_green    (lane_green),
      .lane_blue     (lane_blue),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

endmodule

`default_nettype wire

// ===== sv/tmpu_log2.sv =====
// Pipelined log2 with 32 fraction bits by repeated squaring.
`timescale 1ns / 1ps
`default_nettype none

module tmpu_log2 (
   input  logic                       clock,
   input  logic [31:0]                value,
   output logic [tmpu_pkg::LOG_W-1:0] log_out
);
   import tmpu_pkg::*;

   localparam int SQ = 32;

   logic [4:0]  k_a_ff;
   logic [31:0] v_a_ff;
   logic [4:0]  k_b_ff;
   logic [31:0] m_b_ff;
   logic [4:0]  k_in;

   logic [31:0] m_in [SQ];
   logic [31:0] f_in [SQ];
   logic [31:0] m_ff [SQ];
   logic [31:0] f_ff [SQ];
   logic [4:0]  k_ff [SQ];

   // leading one position
   always_comb begin
      k_in = 5'd0;
      for (int b = 0; b < 32; b++) begin
         if (value[b]) k_in = 5'(b);
      end
   end

   always_comb begin
      logic [31:0] mp;
      logic [31:0] fp;
      logic [63:0] prod;
      mp   = 32'd0;
      fp   = 32'd0;
      prod = 64'd0;
      for (int s = 0; s < SQ; s++) begin
         if (s == 0) begin
            mp = m_b_ff;
            fp = 32'd0;
         end else begin
            mp = m_ff[s-1];
            fp = f_ff[s-1];
         end
         prod = 64'(mp) * 64'(mp);
         f_in[s] = fp;
         if (prod[63]) begin
            m_in[s] = prod[63:32];
            f_in[s][31-s] = 1'b1;
         end else begin
            m_in[s] = prod[62:31];
         end
      end
   end

   always_ff @(posedge clock) begin
      k_a_ff <= k_in;
      v_a_ff <= value;
      k_b_ff <= k_a_ff;
      m_b_ff <= v_a_ff << (5'd31 - k_a_ff);
      for (int s = 0; s < SQ; s++) begin
         m_ff[s] <= m_in[s];
         f_ff[s] <= f_in[s];
         k_ff[s] <= (s == 0) ? k_b_ff : k_ff[s-1];
      end
   end

   assign log_out = {k_ff[SQ-1], f_ff[SQ-1]};

endmodule

`default_nettype wire

// ===== sv/tmpu_lane.sv =====
// One channel lane: clamp, rounding divider and log/exp gamma path.
`timescale 1ns / 1ps
`default_nettype none

module tmpu_lane #(
   parameter int FRAC_BITS = tmpu_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic [31:0]                pixel,
   input  tmpu_pkg::tm_mode_type      mode,
   input  logic [31:0]                max_value,
   input  logic [31:0]                clamp_scale,
   input  logic [15:0]                gamma_exponent,
   input  logic [tmpu_pkg::LOG_W-1:0] log_max,
   output logic [FRAC_BITS:0]         result
);
   import tmpu_pkg::*;

   localparam int OUT_W     = FRAC_BITS + 1;
   localparam int REM_W     = 33 + FRAC_BITS;
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int PAD       = LOG_LAT + EXP_STEPS - 1 - FRAC_BITS;
   localparam int SPEC_LEN  = LOG_LAT + 2 + EXP_STEPS;
   localparam int E_W       = LOG_W + 16;
   localparam logic [OUT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam exp_tab_type EXP_T = exp_table();

   // ---------------- gamma path ----------------
   logic [LOG_W-1:0] log_x;
   gam_spec_type     spec_in;
   gam_spec_type     spec_ff [SPEC_LEN];
   logic [LOG_W-1:0] el_ff;
   logic [E_W-1:0]   e40_ff;
   logic [32:0]      p_in [EXP_STEPS];
   logic [32:0]      p_ff [EXP_STEPS];
   logic [12:0]      n_ff [EXP_STEPS];
   logic [31:0]      f_ff [EXP_STEPS];
   logic [OUT_W-1:0] gam_in;
   logic [OUT_W-1:0] gam_ff;

   tmpu_log2 u_log (
      .clock   (clock),
      .value   (pixel),
      .log_out (log_x)
   );

   assign spec_in.zero = (pixel == 32'd0);
   assign spec_in.one  = (gamma_exponent == 16'd0) || (pixel >= max_value);

   always_comb begin
      logic [32:0] pp;
      logic [31:0] fb;
      logic [65:0] prod;
      pp   = 33'd0;
      fb   = 32'd0;
      prod = 66'd0;
      for (int k = 0; k < EXP_STEPS; k++) begin
         if (k == 0) begin
            pp = 33'h1_0000_0000;
            fb = e40_ff[39:8];
         end else begin
            pp = p_ff[k-1];
            fb = f_ff[k-1];
         end
         prod = 66'(pp) * 66'(EXP_T[k]);
         p_in[k] = fb[31-k] ? prod[64:32] : pp;
      end
   end

   // round half up to FRAC_BITS, saturate
   always_comb begin
      logic [13:0] sh;
      logic [34:0] sum;
      logic [34:0] rnd;
      sh  = {1'b0, n_ff[EXP_STEPS-1]} + 14'(32 - FRAC_BITS);
      sum = 35'(p_ff[EXP_STEPS-1]) + (35'd1 << (sh - 14'd1));
      rnd = sum >> sh;
      if (spec_ff[SPEC_LEN-1].zero) begin
         gam_in = '0;
      end else if (spec_ff[SPEC_LEN-1].one) begin
         gam_in = ONE;
      end else if (sh >= 14'd34) begin
         gam_in = '0;
      end else if (rnd > 35'(ONE)) begin
         gam_in = ONE;
      end else begin
         gam_in = rnd[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SPEC_LEN; i++) begin
         spec_ff[i] <= (i == 0) ? spec_in : spec_ff[i-1];
      end
      el_ff  <= log_max - log_x;
      e40_ff <= E_W'(el_ff) * E_W'(gamma_exponent);
      for (int k = 0; k < EXP_STEPS; k++) begin
         p_ff[k] <= p_in[k];
         n_ff[k] <= (k == 0) ? e40_ff[E_W-1:40] : n_ff[k-1];
         f_ff[k] <= (k == 0) ? e40_ff[39:8] : f_ff[k-1];
      end
      gam_ff <= gam_in;
   end

   // ---------------- linear path ----------------
   logic [63:0]      prod_ff;
   logic [OUT_W-1:0] clamp_ff;
   logic [63:0]      dvd_in;
   logic [REM_W-1:0] dvd_ff;
   logic             sat_ff;
   logic [OUT_W-1:0] clamp2_ff;
   logic [REM_W-1:0] rem_in [DIV_STEPS];
   logic [OUT_W-1:0] q_in   [DIV_STEPS];
   logic [REM_W-1:0] rem_ff [DIV_STEPS];
   logic [OUT_W-1:0] q_ff   [DIV_STEPS];
   logic             sat_d_ff   [DIV_STEPS];
   logic [OUT_W-1:0] clamp_d_ff [DIV_STEPS];
   logic [OUT_W-1:0] lin_in;
   logic [OUT_W-1:0] lin_ff;
   logic [OUT_W-1:0] pad_ff [PAD];

   assign dvd_in = prod_ff + 64'(max_value >> 1);

   always_comb begin
      logic [REM_W-1:0] rp;
      logic [OUT_W-1:0] qp;
      logic [REM_W-1:0] cand;
      rp   = '0;
      qp   = '0;
      cand = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (j == 0) begin
            rp = dvd_ff;
            qp = '0;
         end else begin
            rp = rem_ff[j-1];
            qp = q_ff[j-1];
         end
         cand = REM_W'(max_value) << (FRAC_BITS - j);
         if (rp >= cand) begin
            rem_in[j] = rp - cand;
            q_in[j]   = qp | (OUT_W'(1) << (FRAC_BITS - j));
         end else begin
            rem_in[j] = rp;
            q_in[j]   = qp;
         end
      end
   end

   always_comb begin
      if (mode == MODE_CLAMP) begin
         lin_in = clamp_d_ff[DIV_STEPS-1];
      end else if (sat_d_ff[DIV_STEPS-1]) begin
         lin_in = ONE;
      end else begin
         lin_in = q_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (mode == MODE_EQ_CLAMP) begin
         prod_ff <= 64'(pixel) * 64'(clamp_scale);
      end else begin
         prod_ff <= 64'(pixel) << FRAC_BITS;
      end
      clamp_ff  <= (pixel > 32'(ONE)) ? ONE : pixel[OUT_W-1:0];
      dvd_ff    <= dvd_in[REM_W-1:0];
      sat_ff    <= dvd_in >= ((64'(max_value) << FRAC_BITS) + 64'(max_value));
      clamp2_ff <= clamp_ff;
      for (int j = 0; j < DIV_STEPS; j++) begin
         rem_ff[j]     <= rem_in[j];
         q_ff[j]       <= q_in[j];
         sat_d_ff[j]   <= (j == 0) ? sat_ff : sat_d_ff[j-1];
         clamp_d_ff[j] <= (j == 0) ? clamp2_ff : clamp_d_ff[j-1];
      end
      lin_ff <= lin_in;
      for (int i = 0; i < PAD; i++) begin
         pad_ff[i] <= (i == 0) ? lin_ff : pad_ff[i-1];
      end
      result <= (mode == MODE_GAMMA) ? gam_ff : pad_ff[PAD-1];
   end

endmodule

`default_nettype wire

// ===== sv/tmpu_merge.sv =====
// Output stage: gathers the three lane results into one result transfer.
`timescale 1ns / 1ps
`default_nettype none

module tmpu_merge #(
   parameter int FRAC_BITS = tmpu_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               lane_valid,
   input  logic [FRAC_BITS:0] lane_red,
   input  logic [FRAC_BITS:0] lane_green,
   input  logic [FRAC_BITS:0] lane_blue,
   output logic               rsp_valid,
   output logic [FRAC_BITS:0] rsp_red_out,
   output logic [FRAC_BITS:0] rsp_green_out,
   output logic [FRAC_BITS:0] rsp_blue_out
);
   import tmpu_pkg::*;

   logic               valid_ff;
   logic [FRAC_BITS:0] red_ff;
   logic [FRAC_BITS:0] green_ff;
   logic [FRAC_BITS:0] blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane_valid;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= lane_red;
      green_ff <= lane_green;
      blue_ff  <= lane_blue;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

endmodule

`default_nettype wire

// ===== sv/tmpu_checker.sv =====
// Port-level checker for the tone map pixel unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tmpu_checker #(
   parameter int FRAC_BITS = tmpu_pkg::FRAC_BITS_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [FRAC_BITS:0] rsp_red_out,
   input logic [FRAC_BITS:0] rsp_green_out,
   input logic [FRAC_BITS:0] rsp_blue_out
);
   import tmpu_pkg::*;

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic rsp_in_range;

   assign rsp_in_range = (rsp_red_out <= ONE) && (rsp_green_out <= ONE) &&
                         (rsp_blue_out <= ONE);

   // every pixel transfer yields a result at the fixed latency
   `ASSERT_AFTER(a_rsp_follows, clock, reset, start && !busy, RSP_LAT, rsp_valid)

   // no result without a pixel transfer at the fixed latency
   `ASSERT_IMPLY(a_rsp_sourced, clock, reset, rsp_valid, $past(start && !busy, RSP_LAT))

   // results saturate at 1.0
   `ASSERT_IMPLY(a_rsp_range, clock, reset, rsp_valid, rsp_in_range)

endmodule

bind tone_map_pixel_unit tmpu_checker #(.FRAC_BITS(FRAC_BITS)) u_tmpu_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out)
);

`default_nettype wire

// ===== tb/sv/tone_map_pixel_unit_checker.sv =====
// Checker: predicts the tone map pixel unit's results and compares them.
`timescale 1ns / 1ps
`default_nettype none

module tone_map_pixel_unit_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [31:0] req_red_in,
   input  wire logic [31:0] req_green_in,
   input  wire logic [31:0] req_blue_in,
   input  wire logic        rsp_valid,
   input  wire logic [16:0] rsp_red_out,
   input  wire logic [16:0] rsp_green_out,
   input  wire logic [16:0] rsp_blue_out,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   import tmpu_pkg::*;

   localparam int FB = 16;
   localparam logic [63:0] ONE = 64'd1 << FB;

   typedef struct packed {
      logic [16:0] r;
      logic [16:0] g;
      logic [16:0] b;
   } pixel_out_type;

   tm_mode_type   mode_q;
   logic [31:0]   max_q, scale_q;
   logic [15:0]   gam_q;
   pixel_out_type mapped_q[$];

   function automatic logic [63:0] sat(logic [63:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

   function automatic logic [63:0] log2_fx(logic [31:0] v);
      int k;
      logic [63:0] m, frac;
      k = 0;
      frac = 0;
      while (k < 31 && (v >> (k + 1)) != 0) k++;
      m = {32'd0, v} << (31 - k);
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      return (64'(k) << 32) | frac;
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bm;
      res = 0;
      bm = 64'd1 << 62;
      while (bm > v) bm = bm >> 2;
      while (bm != 0) begin
         if (v >= res + bm) begin
            v = v - (res + bm);
            res = (res >> 1) + bm;
         end else begin
            res = res >> 1;
         end
         bm = bm >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] gamma_map(logic [31:0] x, logic [31:0] m, logic [15:0] g);
      logic [63:0] el, e40, f32, p, t, n, s;
      if (x == 0) return 0;
      if (g == 0 || x >= m) return ONE;
      el = log2_fx(m) - log2_fx(x);
      e40 = el * 64'(g);
      n = e40 >> 40;
      f32 = (e40 >> 8) & 64'hFFFF_FFFF;
      t = 64'd1 << 31;
      p = 64'd1 << 32;
      for (int i = 1; i <= 32; i++) begin
         t = root64(t << 32);
         if ((f32 >> (32 - i)) & 1) p = (p * t) >> 32;
      end
      s = n + 32 - FB;
      if (s >= 64) return 0;
      return sat((p + (64'd1 << (s - 1))) >> s);
   endfunction

   function automatic logic [16:0] map_chan(logic [31:0] x);
      logic [63:0] m;
      m = (max_q != 0) ? 64'(max_q) : 64'd1;
      case (mode_q)
         MODE_CLAMP:    return 17'(sat(64'(x)));
         MODE_EQUALIZE: return 17'(sat(((64'(x) << FB) + (m >> 1)) / m));
         MODE_EQ_CLAMP: return 17'(sat((64'(x) * 64'(scale_q) + (m >> 1)) / m));
         default:       return 17'(gamma_map(x, m[31:0], gam_q));
      endcase
   endfunction

   assign pending_count = mapped_q.size();

   always @(posedge clock) begin
      pixel_out_type e;
      if (reset) begin
         mode_q <= MODE_CLAMP;
         max_q <= 32'd65536;
         scale_q <= 32'd65536;
         gam_q <= 16'd256;
         mapped_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:  mode_q <= tm_mode_type'(csr_wdata[1:0]);
               CSR_MAX:   max_q <= csr_wdata;
               CSR_SCALE: scale_q <= csr_wdata;
               CSR_GAMMA: gam_q <= csr_wdata[15:0];
               default:   ;
            endcase
         end
         if (start && !busy)
            mapped_q.push_back({map_chan(req_red_in), map_chan(req_green_in),
                                map_chan(req_blue_in)});
         if (rsp_valid) begin
            if (mapped_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result transfer");
            end else begin
               e = mapped_q.pop_front();
               if (e != {rsp_red_out, rsp_green_out, rsp_blue_out}) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %h %h %h, got %h %h %h",
                              e.r, e.g, e.b, rsp_red_out, rsp_green_out, rsp_blue_out);
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

// ===== tb/sv/tone_map_pixel_unit_tb.sv =====
// Testbench top: drives pixels and register writes, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none

module tone_map_pixel_unit_tb;
   import tmpu_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic        rsp_valid;
   logic [16:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_MODE;
   logic [31:0] csr_wdata = '0;
   int          fail_count, pending_count;
   logic [31:0] cur_max;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   tone_map_pixel_unit u_dut (
      .clock, .reset, .start, .busy, .req_red_in, .req_green_in, .req_blue_in,
      .rsp_valid, .rsp_red_out, .rsp_green_out, .rsp_blue_out,
      .csr_we, .csr_index, .csr_wdata
   );

   tone_map_pixel_unit_checker u_checker (
      .clock, .reset, .start, .busy, .req_red_in, .req_green_in, .req_blue_in,
      .rsp_valid, .rsp_red_out, .rsp_green_out, .rsp_blue_out,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .pending_count
   );

   // drain: wait for every expected result, then at least the pipeline depth again
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (RSP_LAT + 4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MAX) cur_max = val;
   endtask

   // one pixel transfer; start held until busy is low at an edge
   task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom;
         2: return cur_max;
         3: return (cur_max > 1) ? cur_max - 1 : 32'd0;
         default: return $urandom_range(0, (cur_max > 32'd1) ? cur_max : 32'd2);
      endcase
   endfunction

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int n;
      bit gaps;
      cur_max = 32'd65536;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, clamp extremes
      send_pixel(0, 32'hFFFF_FFFF, 32'd65536, 0);
      send_pixel(32'd65535, 32'd65537, 32'd1, 0);
      start <= 1'b0;
      drain();
      for (int md = 0; md < 4; md++) begin
         write_reg(CSR_MODE, 32'(md));
         write_reg(CSR_MAX, (md == 1) ? 32'd0 : 32'h0008_0000);
         write_reg(CSR_SCALE, (md == 2) ? 32'hFFFF_FFFF : 32'd0);
         write_reg(CSR_GAMMA, (md == 3) ? 16'hFFFF : 16'd0);
         send_pixel(0, 32'hFFFF_FFFF, 32'h0008_0000, 0);
         send_pixel(32'd1, 32'h0007_FFFF, 32'd12345, 0);
         send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'd2, 0);
         start <= 1'b0;
         drain();
      end
      // gamma with the largest max and the smallest nonzero exponent, 1/256
      write_reg(CSR_MAX, 32'hFFFF_FFFF);
      write_reg(CSR_GAMMA, 32'd1);
      send_pixel(1, 32'h8000_0000, 32'd7, 0);
      start <= 1'b0;
      drain();
      write_reg(CSR_GAMMA, 32'd256);

      // random phases
      for (int ph = 0; ph < 22; ph++) begin
         write_reg(CSR_MODE, $urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: write_reg(CSR_MAX, 32'd1);
            1: write_reg(CSR_MAX, 32'hFFFF_FFFF);
            2: write_reg(CSR_MAX, $urandom_range(1, 32'h0010_0000));
            default: write_reg(CSR_MAX, $urandom);
         endcase
         write_reg(CSR_SCALE, ($urandom_range(0, 3) == 0) ? $urandom
                                                         : $urandom_range(0, 32'h0002_0000));
         write_reg(CSR_GAMMA, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(64, 1024));
         gaps = (ph % 3 != 0);
         n = 50;
         for (int i = 0; i < n; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(), gaps);
         start <= 1'b0;
         drain();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

`default_nettype wire
